// ===== hw/rtl/edt_pkg.sv =====
// ----------------------------------------------------------------------------
// edt_pkg: shared types and constants
// widths, codes and the q16 rounding helper for the distribution table
// ----------------------------------------------------------------------------
package edt_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int MAX_VALUE   = 4096;
  localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int LOADED_W    = ENTRY_AW + 1;
  localparam int VAL_W       = 12;
  localparam int CNT_W       = 32;
  localparam int SUM_W       = 44;
  localparam int PPM_W       = 20;
  localparam int FRAC_BITS   = 16;
  localparam int Q_W         = FRAC_BITS + 1;
  localparam int QUO_W       = FRAC_BITS + 2;
  localparam int THR_W       = 64;
  localparam int MULC_W      = CNT_W + PPM_W;

  localparam logic [PPM_W-1:0] PPM_ONE  = PPM_W'(1000000);
  localparam logic [PPM_W-1:0] TAIL_MAX = PPM_W'(999999);
  localparam logic [PPM_W-1:0] TAIL_RST = PPM_W'(1);
  localparam logic [Q_W-1:0]   Q_ONE    = Q_W'(1) << FRAC_BITS;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_QUERY   = 1'b1;
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] prefix;
  } slot_t;

  // round half up of a quotient with one extra bit, limited to 1.0
  function automatic logic [Q_W-1:0] q_round(input logic [QUO_W-1:0] q);
    logic [QUO_W:0] s;
    logic [QUO_W-1:0] h;
    s = {1'b0, q} + (QUO_W+1)'(1);
    h = s[QUO_W:1];
    if (h > QUO_W'(Q_ONE)) begin
      return Q_ONE;
    end
    return h[Q_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/edt_in_if.sv =====
// ----------------------------------------------------------------------------
// edt_in_if: input channel
// load entries and queries, valid/ready transfer
// ----------------------------------------------------------------------------
interface edt_in_if;
  import edt_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [VAL_W-1:0] value;
  logic [CNT_W-1:0] count;
  logic             last;
  logic [VAL_W-1:0] query_point;

  modport source (output valid, op, value, count, last, query_point, input ready);
  modport sink (input valid, op, value, count, last, query_point, output ready);
endinterface

// ===== hw/rtl/edt_out_if.sv =====
// ----------------------------------------------------------------------------
// edt_out_if: result channel
// build summaries and query answers, valid/ready transfer
// ----------------------------------------------------------------------------
interface edt_out_if;
  import edt_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [VAL_W-1:0] min_value;
  logic [VAL_W-1:0] max_value;
  logic [VAL_W-1:0] median_value;
  logic             valid_res;
  logic [Q_W-1:0]   density;
  logic [Q_W-1:0]   cumulative;

  modport source (output valid, kind, min_value, max_value, median_value, valid_res,
                  density, cumulative, input ready);
  modport sink (input valid, kind, min_value, max_value, median_value, valid_res,
                density, cumulative, output ready);
endinterface

// ===== hw/rtl/empirical_distribution_table_top.sv =====
// ----------------------------------------------------------------------------
// empirical_distribution_table_top: histogram to pdf/cdf table
// loads (value, count) entries, builds a value-indexed count and prefix
// table with an upper tail cut, and answers q16 density/cumulative queries
// ----------------------------------------------------------------------------
//  channel   dir   contents
//  in_ch     in    op, value, count, last, query_point
//  out_ch    out   kind, min/max/median, valid_res, density, cumulative
//  cfg       in    cfg_write, cfg_data (tail_ppm)
//
//  a load without last is one write of the entry memory
//  a query passes accept, a table read, an 18-step shared divider and the
//  output write; above the table or with nothing kept it skips the divider
//  a build scans min/max/total over all n entries, walks to the median,
//  forms the threshold, scans for the cutoff (k + 1 entries, or n when none
//  passes), clears the slots below cutoff value c, fills the k kept entries
//  and makes the prefix pass, all paced by the single read port of each memory
//  rst clears control state only; the memories need no clearing pass
//  a finished result waits in the output register; loads keep flowing
// ----------------------------------------------------------------------------
module empirical_distribution_table_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [edt_pkg::PPM_W-1:0] cfg_data,
  edt_in_if.sink                    in_ch,
  edt_out_if.source                 out_ch
);
  import edt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_MED_INIT, S_MED_STEP, S_MED_LOAD, S_MED_VAL, S_KEEP,
    S_CUT, S_CLEAR, S_FILL, S_PREFIX, S_QRD, S_DIV, S_RESULT
  } state_t;

  state_t state;
  logic [1:0] ph;

  // configuration
  logic [PPM_W-1:0] tail_ppm;
  logic [PPM_W-1:0] keep;

  // memories: loaded entries, and the value-indexed count/prefix table
  entry_t ent_mem [MAX_ENTRIES];
  slot_t  tab_mem [MAX_VALUE];
  entry_t ent_q;
  slot_t  tab_q;
  logic [ENTRY_AW-1:0] ent_addr;
  logic [VAL_W-1:0]    tab_addr;
  logic                ent_we;
  logic                tab_we;
  logic [VAL_W-1:0]    tab_waddr;
  slot_t               tab_wdata;

  // load and build state
  logic [LOADED_W-1:0] entries_loaded;
  logic [LOADED_W-1:0] n;
  logic [LOADED_W-1:0] n_new;
  logic [LOADED_W-1:0] idx;
  logic [LOADED_W-1:0] k;
  logic [ENTRY_AW-1:0] lo;
  logic [ENTRY_AW-1:0] hi;
  logic [CNT_W-1:0]    u;
  logic [CNT_W-1:0]    v;
  logic                sel_lo;
  logic [SUM_W-1:0]    total;
  logic [SUM_W-1:0]    cum;
  logic [SUM_W-1:0]    kept;
  logic [SUM_W-1:0]    run;
  logic [SUM_W-1:0]    run_sum;
  logic [THR_W-1:0]    thr;
  logic [THR_W-1:0]    scum;
  logic [THR_W-1:0]    scum_sum;
  logic [41:0]         prod_a;
  logic [41:0]         prod_b;
  logic [MULC_W-1:0]   mulc;
  logic [VAL_W-1:0]    cur_val;
  logic [CNT_W-1:0]    cur_cnt;
  logic [VAL_W-1:0]    cut_val;

  // held build results
  logic [LOADED_W-1:0] table_size;
  logic [SUM_W-1:0]    kept_total;
  logic [VAL_W-1:0]    min_held;
  logic [VAL_W-1:0]    max_held;
  logic [VAL_W-1:0]    median_held;
  logic                built_ok;

  // divider for density (a) and cumulative (b), sharing the denominator
  logic [SUM_W:0]   ra;
  logic [SUM_W:0]   rb;
  logic [QUO_W-1:0] qa;
  logic [QUO_W-1:0] qb;
  logic [4:0]       step;
  logic             ga;
  logic             gb;
  logic [SUM_W:0]   ra_rem;
  logic [SUM_W:0]   rb_rem;

  // result staging and output register
  logic             res_kind;
  logic [Q_W-1:0]   res_dens;
  logic [Q_W-1:0]   res_cdf;
  logic             out_valid;
  logic             out_kind;
  logic [VAL_W-1:0] out_min;
  logic [VAL_W-1:0] out_max;
  logic [VAL_W-1:0] out_med;
  logic             out_ok;
  logic [Q_W-1:0]   out_dens;
  logic [Q_W-1:0]   out_cdf;

  logic in_xfer;
  logic out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // entry written straight from the input so a build can read it at once
  assign ent_we = in_xfer && (in_ch.op == OP_LOAD) &&
                  (entries_loaded < LOADED_W'(MAX_ENTRIES));
  assign n_new  = ent_we ? entries_loaded + LOADED_W'(1) : entries_loaded;

  assign keep     = PPM_ONE - ((tail_ppm > TAIL_MAX) ? TAIL_MAX : tail_ppm);
  assign scum_sum = scum + THR_W'(mulc);
  assign run_sum  = run + SUM_W'(tab_q.cnt);

  assign ga     = ra >= {1'b0, kept_total};
  assign gb     = rb >= {1'b0, kept_total};
  assign ra_rem = ga ? ra - {1'b0, kept_total} : ra;
  assign rb_rem = gb ? rb - {1'b0, kept_total} : rb;

  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = idx[VAL_W-1:0];
    tab_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        tab_we = 1'b1;
      end
      S_FILL: begin
        tab_we        = (ph == 2'd1) && (ent_q.val < cut_val);
        tab_waddr     = ent_q.val;
        tab_wdata.cnt = ent_q.cnt;
      end
      S_PREFIX: begin
        tab_we           = (ph == 2'd1);
        tab_wdata.cnt    = tab_q.cnt;
        tab_wdata.prefix = run_sum;
      end
      default: begin
        tab_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[entries_loaded[ENTRY_AW-1:0]] <= '{val: in_ch.value, cnt: in_ch.count};
    end
    ent_q <= ent_mem[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_q <= tab_mem[tab_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_ppm <= TAIL_RST;
    end else if (cfg_write) begin
      tail_ppm <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ph             <= '0;
      entries_loaded <= '0;
      table_size     <= '0;
      kept_total     <= '0;
      min_held       <= '0;
      max_held       <= '0;
      median_held    <= '0;
      built_ok       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // in S_RESULT the output register is refilled or still held
      if (out_valid && out_ch.ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          ph <= '0;
          if (in_xfer) begin
            if (in_ch.op == OP_LOAD) begin
              if (in_ch.last) begin
                // new build: forget the old table
                entries_loaded <= '0;
                n              <= n_new;
                res_kind       <= KIND_BUILD;
                res_dens       <= '0;
                res_cdf        <= '0;
                table_size     <= '0;
                kept_total     <= '0;
                built_ok       <= 1'b0;
                idx            <= '0;
                ent_addr       <= '0;
                total          <= '0;
                if (n_new == '0) begin
                  min_held    <= '0;
                  max_held    <= '0;
                  median_held <= '0;
                  state       <= S_RESULT;
                end else begin
                  min_held <= '1;
                  max_held <= '0;
                  state    <= S_SCAN;
                end
              end else begin
                entries_loaded <= n_new;
              end
            end else begin
              res_kind <= KIND_QUERY;
              if ({1'b0, in_ch.query_point} < table_size) begin
                tab_addr <= in_ch.query_point;
                state    <= S_QRD;
              end else begin
                // above the table: all the mass lies below
                res_dens <= '0;
                res_cdf  <= Q_ONE;
                state    <= S_RESULT;
              end
            end
          end
        end

        // min, max and total over all entries
        S_SCAN: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph <= '0;
            if (ent_q.val < min_held) min_held <= ent_q.val;
            if (ent_q.val > max_held) max_held <= ent_q.val;
            total <= total + SUM_W'(ent_q.cnt);
            if (idx == n - LOADED_W'(1)) begin
              ent_addr <= '0;
              lo       <= '0;
              hi       <= ENTRY_AW'(n - LOADED_W'(1));
              state    <= S_MED_INIT;
            end else begin
              idx      <= idx + LOADED_W'(1);
              ent_addr <= ent_addr + ENTRY_AW'(1);
            end
          end
        end

        // fetch both ends of the median walk
        S_MED_INIT: begin
          ph <= ph + 2'd1;
          if (ph == 2'd1) begin
            u        <= ent_q.cnt;
            ent_addr <= hi;
          end else if (ph == 2'd3) begin
            v     <= ent_q.cnt;
            state <= S_MED_STEP;
          end
        end

        S_MED_STEP: begin
          ph <= '0;
          if (lo < hi) begin
            if (u <= v) begin
              v        <= v - u;
              lo       <= lo + ENTRY_AW'(1);
              ent_addr <= lo + ENTRY_AW'(1);
              sel_lo   <= 1'b1;
            end else begin
              u        <= u - v;
              hi       <= hi - ENTRY_AW'(1);
              ent_addr <= hi - ENTRY_AW'(1);
              sel_lo   <= 1'b0;
            end
            state <= S_MED_LOAD;
          end else begin
            ent_addr <= lo;
            state    <= S_MED_VAL;
          end
        end

        S_MED_LOAD: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            if (sel_lo) u <= ent_q.cnt;
            else        v <= ent_q.cnt;
            state <= S_MED_STEP;
          end
        end

        S_MED_VAL: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph          <= '0;
            median_held <= ent_q.val;
            state       <= (total == '0) ? S_RESULT : S_KEEP;
          end
        end

        // threshold total * keep in two partial products
        S_KEEP: begin
          unique case (ph)
            2'd0: begin
              prod_a <= 42'(total[SUM_W-1:22]) * 42'(keep);
              ph     <= 2'd1;
            end
            2'd1: begin
              prod_b <= 42'(total[21:0]) * 42'(keep);
              ph     <= 2'd2;
            end
            2'd2: begin
              thr      <= {prod_a, 22'b0} + THR_W'(prod_b);
              idx      <= '0;
              ent_addr <= '0;
              cum      <= '0;
              scum     <= '0;
              ph       <= '0;
              state    <= S_CUT;
            end
            default: ph <= '0;
          endcase
        end

        // first entry whose running count * 1e6 passes the threshold
        S_CUT: begin
          unique case (ph)
            2'd0: ph <= 2'd1;
            2'd1: begin
              mulc    <= MULC_W'(ent_q.cnt) * MULC_W'(PPM_ONE);
              cur_val <= ent_q.val;
              cur_cnt <= ent_q.cnt;
              ph      <= 2'd2;
            end
            2'd2: begin
              ph <= '0;
              if (scum_sum > thr || idx == n - LOADED_W'(1)) begin
                cut_val <= cur_val;
                idx     <= '0;
                if (scum_sum > thr) begin
                  k    <= idx;
                  kept <= cum;
                end else begin
                  k    <= n;
                  kept <= cum + SUM_W'(cur_cnt);
                end
                if (cur_val == '0) begin
                  state <= S_RESULT;
                end else begin
                  state <= S_CLEAR;
                end
              end else begin
                cum      <= cum + SUM_W'(cur_cnt);
                scum     <= scum_sum;
                idx      <= idx + LOADED_W'(1);
                ent_addr <= ent_addr + ENTRY_AW'(1);
              end
            end
            default: ph <= '0;
          endcase
        end

        // zero every slot below the cutoff value
        S_CLEAR: begin
          if (idx[VAL_W-1:0] == cut_val - VAL_W'(1)) begin
            idx      <= '0;
            ent_addr <= '0;
            tab_addr <= '0;
            run      <= '0;
            ph       <= '0;
            state    <= (k == '0) ? S_PREFIX : S_FILL;
          end else begin
            idx <= idx + LOADED_W'(1);
          end
        end

        // scatter kept entries into their value slots
        S_FILL: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph <= '0;
            if (idx == k - LOADED_W'(1)) begin
              idx      <= '0;
              tab_addr <= '0;
              run      <= '0;
              state    <= S_PREFIX;
            end else begin
              idx      <= idx + LOADED_W'(1);
              ent_addr <= ent_addr + ENTRY_AW'(1);
            end
          end
        end

        // running sum written back next to each count
        S_PREFIX: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph  <= '0;
            run <= run_sum;
            if (idx[VAL_W-1:0] == cut_val - VAL_W'(1)) begin
              table_size <= LOADED_W'(cut_val);
              kept_total <= kept;
              built_ok   <= 1'b1;
              state      <= S_RESULT;
            end else begin
              idx      <= idx + LOADED_W'(1);
              tab_addr <= tab_addr + VAL_W'(1);
            end
          end
        end

        S_QRD: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph <= '0;
            if (kept_total == '0) begin
              res_dens <= '0;
              res_cdf  <= '0;
              state    <= S_RESULT;
            end else begin
              ra    <= (SUM_W+1)'(tab_q.cnt);
              rb    <= {1'b0, tab_q.prefix};
              qa    <= '0;
              qb    <= '0;
              step  <= '0;
              state <= S_DIV;
            end
          end
        end

        // restoring division, one quotient bit per cycle for both ratios
        S_DIV: begin
          qa   <= {qa[QUO_W-2:0], ga};
          qb   <= {qb[QUO_W-2:0], gb};
          ra   <= {ra_rem[SUM_W-1:0], 1'b0};
          rb   <= {rb_rem[SUM_W-1:0], 1'b0};
          step <= step + 5'd1;
          if (step == 5'(QUO_W - 1)) begin
            res_dens <= q_round({qa[QUO_W-2:0], ga});
            res_cdf  <= q_round({qb[QUO_W-2:0], gb});
            state    <= S_RESULT;
          end
        end

        S_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= res_kind;
            out_min   <= min_held;
            out_max   <= max_held;
            out_med   <= median_held;
            out_ok    <= built_ok;
            out_dens  <= res_dens;
            out_cdf   <= res_cdf;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = out_kind;
  assign out_ch.min_value    = out_min;
  assign out_ch.max_value    = out_max;
  assign out_ch.median_value = out_med;
  assign out_ch.valid_res    = out_ok;
  assign out_ch.density      = out_dens;
  assign out_ch.cumulative   = out_cdf;

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    entries_loaded <= LOADED_W'(MAX_ENTRIES))
    else $error("load count beyond entry memory");

  a_ok_has_table: assert property (@(posedge clk) disable iff (rst)
    built_ok |-> table_size != '0)
    else $error("valid table with zero size");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> kept_total != '0)
    else $error("divider running on zero denominator");

  a_q_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_QUERY |-> out_dens <= Q_ONE && out_cdf <= Q_ONE)
    else $error("query answer above one");

  a_prefix_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PREFIX |-> idx < LOADED_W'(cut_val))
    else $error("prefix pass past cutoff value");

endmodule
